// File: hdl/dad_pkg.sv
// shared types and constants for the detection anchor decoder
`default_nettype none

package dad_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int CFG_DATA_W  = 23;
    localparam int CFG_INDEX_W = 3;
    localparam int COUNT_W     = 7;
    localparam int COORD_W     = 18;
    localparam int LABEL_W     = 4;
    localparam int ANCHOR_W    = 14;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PW     = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCORE_THRESHOLD = 3'd0,
        REG_LABEL_COUNT     = 3'd1,
        REG_PAD_X           = 3'd2,
        REG_PAD_Y           = 3'd3,
        REG_SCALE_RATIO     = 3'd4,
        REG_IMAGE_WIDTH     = 3'd5,
        REG_IMAGE_HEIGHT    = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [22:0] score_threshold;
        logic [4:0]  label_count;
        logic [22:0] pad_x;
        logic [22:0] pad_y;
        logic [15:0] scale_ratio;
        logic [13:0] image_width;
        logic [13:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] score;
        logic [LABEL_W-1:0]         label;
        logic [ANCHOR_W-1:0]        anchor;
    } det_meta_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] box_x;
        logic signed [SAMPLE_W-1:0] box_y;
        logic signed [SAMPLE_W-1:0] box_w;
        logic signed [SAMPLE_W-1:0] box_h;
        det_meta_t                  meta;
    } det_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

// File: hdl/detection_anchor_decode.sv
// top level of the detection anchor decoder
`default_nettype none

// Streams a detector head's output, one Q11.12 value per beat in anchor-major
// order (centre x, centre y, width, height, then label_count class scores), and
// emits one box beat for each anchor whose best class score is strictly above
// score_threshold. One value is accepted every cycle. A passing anchor enters a
// four-entry queue and then a five-stage pipeline (padding removal, edges,
// scale multiply, clamp, width/height) with a registered output; the input
// stalls only when that queue is full, which can happen only after the output
// has been held in stall. Configuration is written through cfg_write / cfg_index /
// cfg_data and should only change while no detection is in flight. There is no
// clearing pass after reset.
module detection_anchor_decode #(
    parameter int MAX_LABELS  = 16,
    parameter int MAX_ANCHORS = 16384
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [22:0]        cfg_data,
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire logic signed [23:0] sample_value,
    input  wire logic               frame_start,
    output logic                    box_valid,
    input  wire logic               box_stall,
    output logic [17:0]             box_left,
    output logic [17:0]             box_top,
    output logic [17:0]             box_width,
    output logic [17:0]             box_height,
    output logic signed [23:0]      best_score,
    output logic [3:0]              class_label,
    output logic [13:0]             anchor_number
);
    import dad_pkg::*;

    cfg_t           cfg_reg, cfg_next;
    queue_status_t  qstat;
    logic           push, pop;
    det_rec_t       rec_in, rec_out;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_SCORE_THRESHOLD: cfg_next.score_threshold = cfg_data;
                REG_LABEL_COUNT:     cfg_next.label_count     = cfg_data[4:0];
                REG_PAD_X:           cfg_next.pad_x           = cfg_data;
                REG_PAD_Y:           cfg_next.pad_y           = cfg_data;
                REG_SCALE_RATIO:     cfg_next.scale_ratio     = cfg_data[15:0];
                REG_IMAGE_WIDTH:     cfg_next.image_width     = cfg_data[13:0];
                REG_IMAGE_HEIGHT:    cfg_next.image_height    = cfg_data[13:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.score_threshold <= 23'd1024;
            cfg_reg.label_count     <= 5'd9;
            cfg_reg.pad_x           <= '0;
            cfg_reg.pad_y           <= '0;
            cfg_reg.scale_ratio     <= 16'd4096;
            cfg_reg.image_width     <= 14'd640;
            cfg_reg.image_height    <= 14'd640;
        end
        else
            cfg_reg <= cfg_next;
    end

    dad_front #(
        .MAX_LABELS  (MAX_LABELS),
        .MAX_ANCHORS (MAX_ANCHORS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_value (sample_value),
        .frame_start  (frame_start),
        .cfg          (cfg_reg),
        .qstat        (qstat),
        .push         (push),
        .rec          (rec_in)
    );

    dad_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rec_in  (rec_in),
        .pop     (pop),
        .rec_out (rec_out),
        .qstat   (qstat)
    );

    dad_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .qstat         (qstat),
        .rec           (rec_out),
        .pop           (pop),
        .box_valid     (box_valid),
        .box_stall     (box_stall),
        .box_left      (box_left),
        .box_top       (box_top),
        .box_width     (box_width),
        .box_height    (box_height),
        .best_score    (best_score),
        .class_label   (class_label),
        .anchor_number (anchor_number)
    );

endmodule

`default_nettype wire

// File: hdl/dad_front.sv
// front end: channel counting, box latch, running best score and threshold test
`default_nettype none

module dad_front #(
    parameter int MAX_LABELS  = 16,
    parameter int MAX_ANCHORS = 16384
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    output logic                       sample_stall,
    input  wire logic signed [23:0]    sample_value,
    input  wire logic                  frame_start,
    input  wire dad_pkg::cfg_t         cfg,
    input  wire dad_pkg::queue_status_t qstat,
    output logic                       push,
    output dad_pkg::det_rec_t          rec
);
    import dad_pkg::*;

    localparam int CHW = $clog2(MAX_LABELS + 4);
    localparam int AW  = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;

    logic [CHW-1:0]              chan_reg, chan_next, chan_cur;
    logic [AW-1:0]               anchor_reg, anchor_next, anchor_cur, anchor_inc;
    logic signed [SAMPLE_W-1:0]  box_reg [0:3];
    logic signed [SAMPLE_W-1:0]  box_next [0:3];
    logic signed [SAMPLE_W-1:0]  best_reg, best_next, best_new;
    logic [LABEL_W-1:0]          label_reg, label_next, label_new;

    logic                        accept;
    logic [COUNT_W-1:0]          n_eff, lc_ext, last_pos, chan_ext;
    logic                        is_box, is_first, is_last, take, pass;
    logic [AW+ANCHOR_W-1:0]      anchor_wide;

    always_comb
    begin
        accept   = sample_valid && !qstat.full;
        chan_cur   = frame_start ? '0 : chan_reg;
        anchor_cur = frame_start ? '0 : anchor_reg;

        // count is clamped to the supported label range
        lc_ext = COUNT_W'(cfg.label_count);
        if (lc_ext == '0)
            n_eff = COUNT_W'(1);
        else if (lc_ext > COUNT_W'(MAX_LABELS))
            n_eff = COUNT_W'(MAX_LABELS);
        else
            n_eff = lc_ext;

        last_pos = n_eff + COUNT_W'(3);
        chan_ext = COUNT_W'(chan_cur);
        is_box   = chan_ext < COUNT_W'(4);
        is_first = chan_ext == COUNT_W'(4);
        is_last  = !is_box && (chan_ext >= last_pos);

        // strict compare keeps the earlier label on a tie
        take      = is_first || (sample_value > best_reg);
        best_new  = take ? sample_value : best_reg;
        label_new = take ? LABEL_W'(chan_ext - COUNT_W'(4)) : label_reg;
        pass      = $signed({best_new[SAMPLE_W-1], best_new}) >
                    $signed({2'b00, cfg.score_threshold});

        anchor_inc = (anchor_cur == AW'(MAX_ANCHORS - 1)) ? '0 : anchor_cur + 1'b1;
        anchor_wide = {{ANCHOR_W{1'b0}}, anchor_cur};

        chan_next   = chan_reg;
        anchor_next = anchor_reg;
        best_next   = best_reg;
        label_next  = label_reg;
        for (int i = 0; i < 4; i++)
            box_next[i] = box_reg[i];

        if (accept)
        begin
            anchor_next = anchor_cur;
            if (is_box)
            begin
                box_next[chan_cur[1:0]] = sample_value;
                chan_next = chan_cur + 1'b1;
            end
            else
            begin
                best_next  = best_new;
                label_next = label_new;
                if (is_last)
                begin
                    chan_next   = '0;
                    anchor_next = anchor_inc;
                end
                else
                    chan_next = chan_cur + 1'b1;
            end
        end

        push             = accept && is_last && pass;
        rec.box_x        = box_reg[0];
        rec.box_y        = box_reg[1];
        rec.box_w        = box_reg[2];
        rec.box_h        = box_reg[3];
        rec.meta.score   = best_new;
        rec.meta.label   = label_new;
        rec.meta.anchor  = anchor_wide[ANCHOR_W-1:0];
        sample_stall     = qstat.full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg   <= '0;
            anchor_reg <= '0;
            best_reg   <= '0;
            label_reg  <= '0;
            for (int i = 0; i < 4; i++)
                box_reg[i] <= '0;
        end
        else
        begin
            chan_reg   <= chan_next;
            anchor_reg <= anchor_next;
            best_reg   <= best_next;
            label_reg  <= label_next;
            for (int i = 0; i < 4; i++)
                box_reg[i] <= box_next[i];
        end
    end

    // an emitted anchor always restarts the channel count
    a_push_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (chan_reg == '0))
        else $error("channel count not restarted after a detection");

endmodule

`default_nettype wire

// File: hdl/dad_fifo.sv
// short queue of passing detections between front and back ends
`default_nettype none

module dad_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire dad_pkg::det_rec_t      rec_in,
    input  wire logic                   pop,
    output dad_pkg::det_rec_t           rec_out,
    output dad_pkg::queue_status_t      qstat
);
    import dad_pkg::*;

    det_rec_t               mem_reg [0:FIFO_DEPTH-1];
    logic [FIFO_PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PW:0]       count_reg, count_next;

    always_comb
    begin
        qstat.full  = count_reg == (FIFO_PW+1)'(FIFO_DEPTH);
        qstat.empty = count_reg == '0;
        rec_out     = mem_reg[rd_ptr_reg];
        count_next  = count_reg + (FIFO_PW+1)'(push) - (FIFO_PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= rec_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("detection pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("detection popped from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_PW+1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// File: hdl/dad_back.sv
// back end: padding removal, scaling, clamping and output register
`default_nettype none

module dad_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire dad_pkg::cfg_t          cfg,
    input  wire dad_pkg::queue_status_t qstat,
    input  wire dad_pkg::det_rec_t      rec,
    output logic                        pop,
    output logic                        box_valid,
    input  wire logic                   box_stall,
    output logic [17:0]                 box_left,
    output logic [17:0]                 box_top,
    output logic [17:0]                 box_width,
    output logic [17:0]                 box_height,
    output logic signed [23:0]          best_score,
    output logic [3:0]                  class_label,
    output logic [13:0]                 anchor_number
);
    import dad_pkg::*;

    logic en;

    // stage a: centres and half sizes
    logic               a_valid_reg;
    det_meta_t          a_meta_reg;
    logic signed [24:0] a_cx_reg, a_cy_reg;
    logic signed [22:0] a_hw_reg, a_hh_reg;

    // stage b: edges x0, y0, x1, y1
    logic               b_valid_reg;
    det_meta_t          b_meta_reg;
    logic signed [25:0] b_edge_reg [0:3];

    // stage c: edge times ratio
    logic               c_valid_reg;
    det_meta_t          c_meta_reg;
    logic signed [42:0] c_prod_reg [0:3];

    // stage d: clamped Q14.4 edges
    logic               d_valid_reg;
    det_meta_t          d_meta_reg;
    logic [COORD_W-1:0] d_q_reg [0:3];
    logic [COORD_W-1:0] d_q_next [0:3];

    // stage e: output beat
    logic               e_valid_reg;
    det_meta_t          e_meta_reg;
    logic [COORD_W-1:0] e_left_reg, e_top_reg, e_width_reg, e_height_reg;

    logic [COORD_W-1:0] hi_x, hi_y, hi_sel;
    logic [22:0]        q_full;

    always_comb
    begin
        en  = !(e_valid_reg && box_stall);
        pop = en && !qstat.empty;

        hi_x = {cfg.image_width, 4'b0000};
        hi_y = {cfg.image_height, 4'b0000};
        for (int i = 0; i < 4; i++)
        begin
            hi_sel = (i % 2 == 0) ? hi_x : hi_y;
            q_full = c_prod_reg[i][42:20];
            if (c_prod_reg[i][42])
                d_q_next[i] = '0;
            else if (q_full > {5'b00000, hi_sel})
                d_q_next[i] = hi_sel;
            else
                d_q_next[i] = q_full[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= pop;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_meta_reg <= rec.meta;
            a_cx_reg   <= $signed({rec.box_x[23], rec.box_x}) - $signed({2'b00, cfg.pad_x});
            a_cy_reg   <= $signed({rec.box_y[23], rec.box_y}) - $signed({2'b00, cfg.pad_y});
            // arithmetic shift floors toward minus infinity
            a_hw_reg   <= rec.box_w[23:1];
            a_hh_reg   <= rec.box_h[23:1];

            b_meta_reg    <= a_meta_reg;
            b_edge_reg[0] <= 26'(a_cx_reg) - 26'(a_hw_reg);
            b_edge_reg[1] <= 26'(a_cy_reg) - 26'(a_hh_reg);
            b_edge_reg[2] <= 26'(a_cx_reg) + 26'(a_hw_reg);
            b_edge_reg[3] <= 26'(a_cy_reg) + 26'(a_hh_reg);

            c_meta_reg <= b_meta_reg;
            for (int i = 0; i < 4; i++)
                c_prod_reg[i] <= b_edge_reg[i] * $signed({1'b0, cfg.scale_ratio});

            d_meta_reg <= c_meta_reg;
            for (int i = 0; i < 4; i++)
                d_q_reg[i] <= d_q_next[i];

            e_meta_reg   <= d_meta_reg;
            e_left_reg   <= d_q_reg[0];
            e_top_reg    <= d_q_reg[1];
            e_width_reg  <= (d_q_reg[2] >= d_q_reg[0]) ? d_q_reg[2] - d_q_reg[0] : '0;
            e_height_reg <= (d_q_reg[3] >= d_q_reg[1]) ? d_q_reg[3] - d_q_reg[1] : '0;
        end
    end

    assign box_valid     = e_valid_reg;
    assign box_left      = e_left_reg;
    assign box_top       = e_top_reg;
    assign box_width     = e_width_reg;
    assign box_height    = e_height_reg;
    assign best_score    = e_meta_reg.score;
    assign class_label   = e_meta_reg.label;
    assign anchor_number = e_meta_reg.anchor;

    // a frozen pipeline keeps its work
    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg && !en) |=> d_valid_reg)
        else $error("pipeline stage lost a detection while frozen");

    a_drop_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(box_valid) |-> $past(!box_stall))
        else $error("output beat dropped without being taken");

endmodule

`default_nettype wire

// File: verif/dad_box_checker.sv
// scoreboard for the detection anchor decoder: predicts box beats and compares them
`timescale 1ns / 100ps

module dad_box_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [22:0]        cfg_data,
    input  logic               sample_valid,
    input  logic               sample_stall,
    input  logic signed [23:0] sample_value,
    input  logic               frame_start,
    input  logic               box_valid,
    input  logic               box_stall,
    input  logic [17:0]        box_left,
    input  logic [17:0]        box_top,
    input  logic [17:0]        box_width,
    input  logic [17:0]        box_height,
    input  logic signed [23:0] best_score,
    input  logic [3:0]         class_label,
    input  logic [13:0]        anchor_number,
    input  logic               end_of_run,
    output int                 fail_count,
    output int                 pending_count,
    output int                 boxes_checked
);
    import dad_pkg::*;

    localparam int LABEL_LIMIT = 16;
    localparam int ANCHOR_WRAP = 16384;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        logic [17:0]        left;
        logic [17:0]        top;
        logic [17:0]        width;
        logic [17:0]        height;
        logic signed [23:0] score;
        logic [3:0]         label;
        logic [13:0]        anchor;
    } box_beat_t;

    // register copies
    logic [22:0] threshold_reg;
    logic [4:0]  labels_reg;
    logic [22:0] pad_x_reg;
    logic [22:0] pad_y_reg;
    logic [15:0] ratio_reg;
    logic [13:0] width_reg;
    logic [13:0] height_reg;

    // decoder state
    int unsigned        channel_idx;
    int unsigned        anchor_idx;
    logic signed [23:0] box_hold [4];
    logic signed [23:0] best_hold;
    logic [3:0]         best_label;

    box_beat_t pending_boxes [$];
    int        fails = 0;
    int        checked = 0;
    bit        closed = 1'b0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fails++;
        if (fails <= PRINT_CAP)
            $display("%t mismatch: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Q11.12 edge to Q14.4 original pixels, clamped to [0, dim*16]
    function automatic longint scale_edge(input longint edge_q12, input logic [15:0] ratio,
                                          input logic [13:0] dim);
        longint prod;
        longint lim;
        longint q;
        prod = edge_q12 * longint'(ratio);
        lim = longint'(dim) * 16;
        if (prod < 0)
            return 0;
        q = prod >>> 20;
        if (q > lim)
            q = lim;
        return q;
    endfunction

    task automatic take_value(input logic signed [23:0] v, input logic fs);
        int unsigned n;
        int unsigned c;
        longint      cx;
        longint      cy;
        longint      hw;
        longint      hh;
        longint      x0;
        longint      y0;
        longint      x1;
        longint      y1;
        box_beat_t   beat;
        n = labels_reg;
        if (n < 1)
            n = 1;
        if (n > LABEL_LIMIT)
            n = LABEL_LIMIT;
        if (fs)
        begin
            channel_idx = 0;
            anchor_idx = 0;
        end
        c = channel_idx;
        if (c < 4)
        begin
            box_hold[c] = v;
            channel_idx = c + 1;
            return;
        end
        // first score always loads, later ones only when strictly higher
        if (c == 4 || v > best_hold)
        begin
            best_hold = v;
            best_label = 4'(c - 4);
        end
        // a count lowered mid-anchor ends the anchor at the first score past it
        if (c < 3 + n)
        begin
            channel_idx = c + 1;
            return;
        end
        if (longint'(best_hold) > longint'(threshold_reg))
        begin
            cx = longint'(box_hold[0]) - longint'(pad_x_reg);
            cy = longint'(box_hold[1]) - longint'(pad_y_reg);
            hw = longint'(box_hold[2]) >>> 1;
            hh = longint'(box_hold[3]) >>> 1;
            x0 = scale_edge(cx - hw, ratio_reg, width_reg);
            y0 = scale_edge(cy - hh, ratio_reg, height_reg);
            x1 = scale_edge(cx + hw, ratio_reg, width_reg);
            y1 = scale_edge(cy + hh, ratio_reg, height_reg);
            beat.left = 18'(x0);
            beat.top = 18'(y0);
            beat.width = (x1 > x0) ? 18'(x1 - x0) : 18'd0;
            beat.height = (y1 > y0) ? 18'(y1 - y0) : 18'd0;
            beat.score = best_hold;
            beat.label = best_label;
            beat.anchor = 14'(anchor_idx);
            pending_boxes = {pending_boxes, beat};
        end
        channel_idx = 0;
        anchor_idx = (anchor_idx + 1) % ANCHOR_WRAP;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        box_beat_t got;
        box_beat_t want;
        if (!rst_n)
        begin
            threshold_reg = 23'd1024;
            labels_reg = 5'd9;
            pad_x_reg = '0;
            pad_y_reg = '0;
            ratio_reg = 16'd4096;
            width_reg = 14'd640;
            height_reg = 14'd640;
            channel_idx = 0;
            anchor_idx = 0;
            foreach (box_hold[i])
                box_hold[i] = '0;
            best_hold = '0;
            best_label = '0;
            pending_boxes.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SCORE_THRESHOLD: threshold_reg = cfg_data;
                    REG_LABEL_COUNT:     labels_reg = cfg_data[4:0];
                    REG_PAD_X:           pad_x_reg = cfg_data;
                    REG_PAD_Y:           pad_y_reg = cfg_data;
                    REG_SCALE_RATIO:     ratio_reg = cfg_data[15:0];
                    REG_IMAGE_WIDTH:     width_reg = cfg_data[13:0];
                    REG_IMAGE_HEIGHT:    height_reg = cfg_data[13:0];
                    default: ;
                endcase
            end
            if (box_valid && !box_stall)
            begin
                got = '{box_left, box_top, box_width, box_height, best_score, class_label,
                        anchor_number};
                if (pending_boxes.size() == 0)
                    report_mismatch("box beat with nothing expected, anchor", got.anchor, -1);
                else
                begin
                    want = pending_boxes.pop_front();
                    checked++;
                    if (got.left != want.left)
                        report_mismatch($sformatf("anchor %0d box_left", want.anchor),
                                        got.left, want.left);
                    if (got.top != want.top)
                        report_mismatch($sformatf("anchor %0d box_top", want.anchor),
                                        got.top, want.top);
                    if (got.width != want.width)
                        report_mismatch($sformatf("anchor %0d box_width", want.anchor),
                                        got.width, want.width);
                    if (got.height != want.height)
                        report_mismatch($sformatf("anchor %0d box_height", want.anchor),
                                        got.height, want.height);
                    if (got.score != want.score)
                        report_mismatch($sformatf("anchor %0d best_score", want.anchor),
                                        got.score, want.score);
                    if (got.label != want.label)
                        report_mismatch($sformatf("anchor %0d class_label", want.anchor),
                                        got.label, want.label);
                    if (got.anchor != want.anchor)
                        report_mismatch("anchor_number", got.anchor, want.anchor);
                end
            end
            if (sample_valid && !sample_stall)
                take_value(sample_value, frame_start);
            if (end_of_run && !closed)
            begin
                closed = 1'b1;
                while (pending_boxes.size() != 0)
                begin
                    want = pending_boxes.pop_front();
                    report_mismatch("box never came, anchor", -1, want.anchor);
                end
            end
        end
        fail_count <= fails;
        pending_count <= pending_boxes.size();
        boxes_checked <= checked;
    end

endmodule

// File: verif/tb_detection_anchor_decode.sv
// testbench top for the detection anchor decoder: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_detection_anchor_decode;
    import dad_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 500;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [22:0]        cfg_data = '0;
    logic               sample_valid = 1'b0;
    logic               sample_stall;
    logic signed [23:0] sample_value = '0;
    logic               frame_start = 1'b0;
    logic               box_valid;
    logic               box_stall = 1'b0;
    logic [17:0]        box_left;
    logic [17:0]        box_top;
    logic [17:0]        box_width;
    logic [17:0]        box_height;
    logic signed [23:0] best_score;
    logic [3:0]         class_label;
    logic [13:0]        anchor_number;
    logic               end_of_run = 1'b0;
    int                 fail_count;
    int                 pending_count;
    int                 boxes_checked;

    // stimulus bookkeeping
    int          values_sent = 0;
    int          regs_written = 0;
    int          settings_used = 1;
    int          send_run = 0;
    int          stall_run = 0;
    logic [22:0] thr_shadow = 23'd1024;
    logic [4:0]  labels_shadow = 5'd9;

    detection_anchor_decode dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample_value  (sample_value),
        .frame_start   (frame_start),
        .box_valid     (box_valid),
        .box_stall     (box_stall),
        .box_left      (box_left),
        .box_top       (box_top),
        .box_width     (box_width),
        .box_height    (box_height),
        .best_score    (best_score),
        .class_label   (class_label),
        .anchor_number (anchor_number)
    );

    dad_box_checker u_box_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample_value  (sample_value),
        .frame_start   (frame_start),
        .box_valid     (box_valid),
        .box_stall     (box_stall),
        .box_left      (box_left),
        .box_top       (box_top),
        .box_width     (box_width),
        .box_height    (box_height),
        .best_score    (best_score),
        .class_label   (class_label),
        .anchor_number (anchor_number),
        .end_of_run    (end_of_run),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .boxes_checked (boxes_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin : watchdog
        #1_000_000;
        $display("run timed out with %0d boxes outstanding", pending_count);
        $display("end of test: mismatches");
        $finish;
    end

    // idle draws with occasional stretches of back-to-back beats
    function automatic int sender_gap();
        if (send_run > 0)
        begin
            send_run--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            send_run = 20;
        return $urandom_range(0, 10);
    endfunction

    function automatic int stall_gap();
        if (stall_run > 0)
        begin
            stall_run--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            stall_run = 8;
        return $urandom_range(0, 10);
    endfunction

    function automatic int score_slots();
        if (labels_shadow < 1)
            return 1;
        if (labels_shadow > 16)
            return 16;
        return labels_shadow;
    endfunction

    function automatic logic signed [23:0] px(input int pixels);
        return 24'(pixels * 4096);
    endfunction

    function automatic logic signed [23:0] pick_centre();
        if ($urandom_range(0, 9) == 0)
            return 24'($urandom);
        return 24'($urandom_range(0, 700 * 4096));
    endfunction

    function automatic logic signed [23:0] pick_extent();
        if ($urandom_range(0, 9) == 0)
            return 24'($urandom);
        return 24'($urandom_range(0, 400 * 4096));
    endfunction

    // mostly near the threshold so both outcomes show up, with ties and noise
    function automatic logic signed [23:0] pick_score(input logic signed [23:0] prev);
        int r;
        int t;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 24'($urandom);
        if (r == 1)
            return prev;
        t = int'(thr_shadow) + int'($urandom_range(0, 8192)) - 4096;
        return 24'(t);
    endfunction

    // holds the beat until accepted; valid stays up when the next beat follows at once
    task automatic send_value(input logic signed [23:0] v, input bit fs);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_value <= v;
        frame_start <= fs;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        values_sent++;
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // the write enable is lowered after the write flagged as the last of a batch
    task automatic write_reg(input reg_index_t idx, input logic [22:0] val, input bit last);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (last)
            cfg_write <= 1'b0;
        regs_written++;
        if (idx == REG_SCORE_THRESHOLD)
            thr_shadow = val;
        if (idx == REG_LABEL_COUNT)
            labels_shadow = val[4:0];
    endtask

    task automatic program_phase(input int k);
        logic [22:0] setting [7];
        int          r;
        case (k)
            1:
            begin
                setting = '{23'h7FFFFF, 23'd31, 23'h7FFFFF, 23'h7FFFFF, 23'hFFFF, 23'h3FFF,
                            23'h3FFF};
            end
            2:
            begin
                setting = '{23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0};
            end
            3:
            begin
                setting = '{23'd0, 23'd16, 23'h7FFFFF, 23'h7FFFFF, 23'hFFFF, 23'h3FFF,
                            23'h3FFF};
            end
            default:
            begin
                r = $urandom_range(0, 9);
                setting[REG_SCORE_THRESHOLD] = (r == 0) ? 23'd0 : (r == 1) ? 23'h7FFFFF :
                                               23'($urandom_range(0, 20000));
                setting[REG_LABEL_COUNT] = ($urandom_range(0, 3) == 0) ?
                                           23'($urandom_range(0, 31)) :
                                           23'($urandom_range(1, 16));
                r = $urandom_range(0, 9);
                setting[REG_PAD_X] = (r == 0) ? 23'h7FFFFF : (r < 4) ? 23'd0 :
                                     23'($urandom_range(0, 100 * 4096));
                r = $urandom_range(0, 9);
                setting[REG_PAD_Y] = (r == 0) ? 23'h7FFFFF : (r < 4) ? 23'd0 :
                                     23'($urandom_range(0, 100 * 4096));
                r = $urandom_range(0, 9);
                setting[REG_SCALE_RATIO] = (r == 0) ? 23'd0 : (r == 1) ? 23'hFFFF :
                                           23'($urandom_range(2048, 12288));
                r = $urandom_range(0, 9);
                setting[REG_IMAGE_WIDTH] = (r == 0) ? 23'd0 : (r == 1) ? 23'h3FFF :
                                           23'($urandom_range(1, 8192));
                r = $urandom_range(0, 9);
                setting[REG_IMAGE_HEIGHT] = (r == 0) ? 23'd0 : (r == 1) ? 23'h3FFF :
                                            23'($urandom_range(1, 8192));
            end
        endcase
        for (int i = 0; i < 7; i++)
            write_reg(reg_index_t'(i), setting[i], i == 6);
        settings_used++;
    endtask

    task automatic send_anchor(input bit new_frame);
        logic signed [23:0] score;
        int                 slots;
        slots = score_slots();
        send_value(pick_centre(), new_frame);
        send_value(pick_centre(), 1'b0);
        send_value(pick_extent(), 1'b0);
        send_value(pick_extent(), 1'b0);
        score = pick_score(24'sd0);
        for (int i = 0; i < slots; i++)
        begin
            if (i == 0 || $urandom_range(0, 3) != 0)
                score = pick_score(score);
            send_value(score, 1'b0);
        end
    endtask

    // mostly well-formed anchors, some noise beats and cut-off anchors
    task automatic run_phase(input int stop_at);
        bit realign;
        int r;
        int cut;
        realign = 1'b1;
        while (values_sent < stop_at)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
            begin
                send_value(24'($urandom), 1'($urandom));
                realign = 1'b1;
            end
            else if (r == 1)
            begin
                cut = $urandom_range(1, 3 + score_slots());
                for (int i = 0; i < cut; i++)
                    send_value(24'($urandom), i == 0 && realign);
                realign = 1'b1;
            end
            else
            begin
                send_anchor(realign || r == 2);
                realign = 1'b0;
            end
        end
    endtask

    initial
    begin : result_side
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = stall_gap();
            if (hold > 0)
            begin
                box_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                box_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(box_valid && !box_stall))
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int k;
        int target;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_LABEL_COUNT, 23'd2, 1'b1);
        // extreme box values, tie at the top score
        send_value(24'sh7FFFFF, 1'b1);
        send_value(24'sh800000, 1'b0);
        send_value(24'sh7FFFFF, 1'b0);
        send_value(24'sh800000, 1'b0);
        send_value(24'sh7FFFFF, 1'b0);
        send_value(24'sh7FFFFF, 1'b0);
        // negative height, lowest and zero scores both below the threshold: nothing comes out
        send_value(px(100), 1'b0);
        send_value(px(50), 1'b0);
        send_value(px(20), 1'b0);
        send_value(px(-8), 1'b0);
        send_value(24'sh800000, 1'b0);
        send_value(24'sd0, 1'b0);
        // left edge off the image, second label wins
        send_value(px(5), 1'b0);
        send_value(px(600), 1'b0);
        send_value(px(40), 1'b0);
        send_value(px(90), 1'b0);
        send_value(24'sd1025, 1'b0);
        send_value(24'sd2000, 1'b0);
        // frame restart partway through an anchor, best score equal to the threshold
        send_value(px(300), 1'b0);
        send_value(px(200), 1'b0);
        send_value(px(320), 1'b1);
        send_value(px(240), 1'b0);
        send_value(px(64), 1'b0);
        send_value(px(48), 1'b0);
        send_value(24'sd1024, 1'b0);
        send_value(24'sd1024, 1'b0);
        // label count lowered in the middle of an anchor
        wait_drained();
        write_reg(REG_LABEL_COUNT, 23'd6, 1'b1);
        send_value(px(100), 1'b0);
        send_value(px(100), 1'b0);
        send_value(px(30), 1'b0);
        send_value(px(30), 1'b0);
        send_value(24'sd3000, 1'b0);
        send_value(24'sd3000, 1'b0);
        send_value(24'sd2500, 1'b0);
        wait_drained();
        write_reg(REG_LABEL_COUNT, 23'd2, 1'b1);
        send_value(24'sd2999, 1'b0);

        target = values_sent + RANDOM_ITEMS;
        k = 0;
        while (values_sent < target)
        begin
            wait_drained();
            if (k > 0)
                program_phase(k);
            run_phase(values_sent + $urandom_range(60, 100));
            k++;
        end
        wait_drained();

        end_of_run <= 1'b1;
        repeat (3) @(posedge clk);
        $display("covered %0d input values and %0d box beats under %0d register settings",
                 values_sent, boxes_checked, settings_used);
        $display("%0d register writes; frame restarts, cut-off anchors and output stalls mixed in",
                 regs_written);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
hdl/dad_pkg.sv
hdl/dad_front.sv
hdl/dad_fifo.sv
hdl/dad_back.sv
hdl/detection_anchor_decode.sv
verif/dad_box_checker.sv
verif/tb_detection_anchor_decode.sv
